// File: sv/ldsc_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// ldsc_pkg
// Shared widths and sequencer states for the Diophantine solution counter.
// ---------------------------------------------------------------------------
package ldsc_pkg;

  localparam int VALUE_BITS = 31;
  localparam int WIDE_BITS  = 2 * VALUE_BITS;
  localparam int SGN_BITS   = VALUE_BITS + 3;
  localparam int CNT_BITS   = $clog2(WIDE_BITS + 1);
  localparam int COUNT_BITS = 32;

  typedef enum logic [4:0] {
    S_IDLE, S_DIV, S_MUL, S_GCD, S_GCD2, S_CHKD, S_RA, S_RB, S_RD,
    S_INV0, S_INV, S_INV1, S_INV2, S_INVF, S_Y1, S_Y2, S_Y3, S_Y4,
    S_C1, S_C2, S_OUT
  } state_t;

endpackage

// File: sv/linear_diophantine_solution_count_top.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// linear_diophantine_solution_count_top
// Counts non-negative (x,y) with weight_a*x + weight_b*y = target.
// ---------------------------------------------------------------------------
// One request at a time. All division and multiplication runs through one
// restoring divider (one quotient bit per cycle) and one shift-add multiplier
// (one bit per cycle) under a small sequencer: gcd, reduction, extended Euclid
// inverse, then the least y and the count. Divisions and multiplies are 31-bit,
// but for the 62-bit remainder step on the product. The run time is data
// dependent and grows with the number of Euclid steps for the gcd and for the
// inverse. The result is held until taken; in_stall stays high from accept
// until then.
module linear_diophantine_solution_count_top (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [ldsc_pkg::VALUE_BITS-1:0]     weight_a,
  input  logic [ldsc_pkg::VALUE_BITS-1:0]     weight_b,
  input  logic [ldsc_pkg::VALUE_BITS-1:0]     target,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [ldsc_pkg::COUNT_BITS-1:0]     solution_count
);
  import ldsc_pkg::*;

  localparam int VB = VALUE_BITS;
  localparam int WB = WIDE_BITS;

  state_t state, state_next, ret, ret_next;

  logic [VB-1:0]       ra, ra_next, rb, rb_next, rd, rd_next, rg, rg_next;
  logic [VB-1:0]       r0, r0_next, r1, r1_next;
  logic [VB-1:0]       inv, inv_next, y0, y0_next;
  logic signed [SGN_BITS-1:0] s0, s0_next, s1, s1_next;
  logic [VB-1:0]       div_rem, div_rem_next, div_dvs, div_dvs_next;
  logic [WB-1:0]       div_dq, div_dq_next;
  logic [WB-1:0]       mul_acc, mul_acc_next, mul_mc, mul_mc_next;
  logic [VB-1:0]       mul_mp, mul_mp_next;
  logic [CNT_BITS-1:0] cnt, cnt_next;
  logic [COUNT_BITS-1:0] result, result_next;

  logic [VB:0]         trial;
  logic                tbit;
  logic signed [SGN_BITS-1:0] sfix;
  logic [VB:0]         cplus;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      ret   <= S_IDLE;
    end else begin
      state <= state_next;
      ret   <= ret_next;
    end
    ra <= ra_next; rb <= rb_next; rd <= rd_next; rg <= rg_next;
    r0 <= r0_next; r1 <= r1_next;
    inv <= inv_next; y0 <= y0_next; s0 <= s0_next; s1 <= s1_next;
    div_rem <= div_rem_next; div_dvs <= div_dvs_next; div_dq <= div_dq_next;
    mul_acc <= mul_acc_next; mul_mc <= mul_mc_next; mul_mp <= mul_mp_next;
    cnt <= cnt_next; result <= result_next;
  end

  always_comb begin
    state_next = state; ret_next = ret;
    ra_next = ra; rb_next = rb; rd_next = rd; rg_next = rg;
    r0_next = r0; r1_next = r1;
    inv_next = inv; y0_next = y0; s0_next = s0; s1_next = s1;
    div_rem_next = div_rem; div_dvs_next = div_dvs; div_dq_next = div_dq;
    mul_acc_next = mul_acc; mul_mc_next = mul_mc; mul_mp_next = mul_mp;
    cnt_next = cnt; result_next = result;

    trial = {div_rem, div_dq[WB-1]} - {1'b0, div_dvs};
    tbit  = ~trial[VB];
    sfix  = s0;
    if (s0 < 0) begin
      sfix = s0 + $signed({{(SGN_BITS-VB){1'b0}}, ra});
    end else if (s0 >= $signed({{(SGN_BITS-VB){1'b0}}, ra})) begin
      sfix = s0 - $signed({{(SGN_BITS-VB){1'b0}}, ra});
    end
    cplus = {1'b0, div_dq[VB-1:0]} + {{VB{1'b0}}, 1'b1};

    in_stall  = (state != S_IDLE);
    out_valid = (state == S_OUT);

    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          ra_next = weight_a; rb_next = weight_b; rd_next = target;
          r0_next = weight_a; r1_next = weight_b;
          if (weight_a == '0 || weight_b == '0) begin
            result_next = '0;
            state_next  = S_OUT;
          end else begin
            state_next = S_GCD;
          end
        end
      end
      S_DIV: begin
        div_rem_next = tbit ? trial[VB-1:0] : {div_rem[VB-2:0], div_dq[WB-1]};
        div_dq_next  = {div_dq[WB-2:0], tbit};
        cnt_next     = cnt - 1'b1;
        if (cnt == CNT_BITS'(1)) state_next = ret;
      end
      S_MUL: begin
        if (mul_mp[0]) mul_acc_next = mul_acc + mul_mc;
        mul_mc_next = {mul_mc[WB-2:0], 1'b0};
        mul_mp_next = {1'b0, mul_mp[VB-1:1]};
        cnt_next    = cnt - 1'b1;
        if (cnt == CNT_BITS'(1)) state_next = ret;
      end
      S_GCD: begin
        div_rem_next = '0;
        cnt_next     = CNT_BITS'(VB);
        state_next   = S_DIV;
        if (r1 == '0) begin
          rg_next      = r0;
          div_dq_next  = {rd, {(WB-VB){1'b0}}};
          div_dvs_next = r0;
          ret_next     = S_CHKD;
        end else begin
          div_dq_next  = {r0, {(WB-VB){1'b0}}};
          div_dvs_next = r1;
          ret_next     = S_GCD2;
        end
      end
      S_GCD2: begin
        r0_next = r1; r1_next = div_rem; state_next = S_GCD;
      end
      S_CHKD: begin
        if (div_rem != '0) begin
          result_next = '0; state_next = S_OUT;
        end else if (rd == '0) begin
          result_next = COUNT_BITS'(1); state_next = S_OUT;
        end else begin
          rd_next = div_dq[VB-1:0];
          div_rem_next = '0; div_dq_next = {ra, {(WB-VB){1'b0}}};
          div_dvs_next = rg; cnt_next = CNT_BITS'(VB);
          ret_next = S_RA; state_next = S_DIV;
        end
      end
      S_RA: begin
        ra_next = div_dq[VB-1:0];
        div_rem_next = '0; div_dq_next = {rb, {(WB-VB){1'b0}}};
        div_dvs_next = rg; cnt_next = CNT_BITS'(VB);
        ret_next = S_RB; state_next = S_DIV;
      end
      S_RB: begin
        // d was already divided by g in S_CHKD
        rb_next = div_dq[VB-1:0];
        state_next = S_RD;
      end
      S_RD: begin
        div_rem_next = '0; div_dq_next = {rb, {(WB-VB){1'b0}}};
        div_dvs_next = ra; cnt_next = CNT_BITS'(VB);
        ret_next = S_INV0; state_next = S_DIV;
      end
      S_INV0: begin
        r0_next = div_rem; r1_next = ra;
        s0_next = SGN_BITS'(1); s1_next = '0;
        state_next = S_INV;
      end
      S_INV: begin
        if (r1 == '0) begin
          state_next = S_INVF;
        end else begin
          div_rem_next = '0; div_dq_next = {r0, {(WB-VB){1'b0}}};
          div_dvs_next = r1; cnt_next = CNT_BITS'(VB);
          ret_next = S_INV1; state_next = S_DIV;
        end
      end
      S_INV1: begin
        r0_next = r1; r1_next = div_rem;
        mul_acc_next = '0;
        mul_mc_next  = WB'(s1);
        mul_mp_next  = div_dq[VB-1:0];
        cnt_next = CNT_BITS'(VB);
        ret_next = S_INV2; state_next = S_MUL;
      end
      S_INV2: begin
        s0_next = s1;
        s1_next = s0 - $signed(mul_acc[SGN_BITS-1:0]);
        state_next = S_INV;
      end
      S_INVF: begin
        inv_next = sfix[VB-1:0];
        div_rem_next = '0; div_dq_next = {rd, {(WB-VB){1'b0}}};
        div_dvs_next = ra; cnt_next = CNT_BITS'(VB);
        ret_next = S_Y1; state_next = S_DIV;
      end
      S_Y1: begin
        mul_acc_next = '0; mul_mc_next = WB'(div_rem); mul_mp_next = inv;
        cnt_next = CNT_BITS'(VB);
        ret_next = S_Y2; state_next = S_MUL;
      end
      S_Y2: begin
        // full-width remainder of the product
        div_rem_next = '0; div_dq_next = mul_acc;
        div_dvs_next = ra; cnt_next = CNT_BITS'(WB);
        ret_next = S_Y3; state_next = S_DIV;
      end
      S_Y3: begin
        y0_next = div_rem;
        mul_acc_next = '0; mul_mc_next = WB'(div_rem); mul_mp_next = rb;
        cnt_next = CNT_BITS'(VB);
        ret_next = S_Y4; state_next = S_MUL;
      end
      S_Y4: begin
        if (mul_acc > WB'(rd)) begin
          result_next = '0; state_next = S_OUT;
        end else begin
          div_rem_next = '0; div_dq_next = {rd, {(WB-VB){1'b0}}};
          div_dvs_next = rb; cnt_next = CNT_BITS'(VB);
          ret_next = S_C1; state_next = S_DIV;
        end
      end
      S_C1: begin
        div_rem_next = '0;
        div_dq_next  = {div_dq[VB-1:0] - y0, {(WB-VB){1'b0}}};
        div_dvs_next = ra; cnt_next = CNT_BITS'(VB);
        ret_next = S_C2; state_next = S_DIV;
      end
      S_C2: begin
        // count saturates when it would not fit the output
        if (VB >= COUNT_BITS && (&div_dq[VB-1:0])) begin
          result_next = '1;
        end else begin
          result_next = COUNT_BITS'(cplus);
        end
        state_next  = S_OUT;
      end
      S_OUT: begin
        if (!out_stall) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  assign solution_count = result;

  a_out_blocks_in: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> in_stall) else $error("input open while result pending");
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> in_stall) else $error("not busy after accept");
  a_div_nonzero: assert property (@(posedge clk) disable iff (rst)
    (state == S_DIV) |-> (div_dvs != '0)) else $error("divide by zero");
  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_stall) |=> !in_stall) else $error("not idle after delivery");

endmodule
